FILE: hw/rtl/vsc_pkg.sv
// Shared types, codes and helpers for the viewport scroll clamp.
`timescale 1ns / 1ps
`default_nettype none

package vsc_pkg;

  // Default coordinate width; the block is built for 8 to 32 bits.
  localparam int COORD_BITS_DEF = 16;

  // Working width of the saturation helper, wider than any coordinate sum.
  localparam int SAT_W = 40;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  localparam int VIEW_W_RST = 320;
  localparam int VIEW_H_RST = 240;

  // Bits of the mode register.
  localparam int MODE_LIMIT_BIT  = 0;
  localparam int MODE_MARGIN_BIT = 1;
  localparam int MODE_CART_BIT   = 2;

  typedef enum logic [2:0] {
    CFG_MODE          = 3'd0,
    CFG_VIEW_W        = 3'd1,
    CFG_VIEW_H        = 3'd2,
    CFG_LIM_BASE      = 3'd3,
    CFG_LIMIT_SIZE    = 3'd4,
    CFG_MARGIN_ORIGIN = 3'd5,
    CFG_MARGIN_SIZE   = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_GOTO   = 2'd0,
    KIND_MOVE   = 2'd1,
    KIND_CENTER = 2'd2,
    KIND_RECT   = 2'd3
  } kind_e;

  // Operation left for the back end once the front has classified an item.
  typedef enum logic [1:0] {
    OP_ABS    = 2'd0,
    OP_REL    = 2'd1,
    OP_MARGIN = 2'd2
  } op_e;

  typedef struct packed {
    logic [2:0]  mode;
    logic [14:0] view_w;
    logic [14:0] view_h;
    logic [31:0] lim_base;
    logic [31:0] limit_size;
    logic [31:0] margin_origin;
    logic [31:0] margin_size;
  } cfg_t;

  // Saturate v to a signed value of cb bits.
  function automatic logic signed [SAT_W-1:0] sat_coord(input logic signed [SAT_W-1:0] v,
                                                        input int unsigned cb);
    logic signed [SAT_W-1:0] one;
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    logic signed [SAT_W-1:0] r;
    one = SAT_W'(signed'(1));
    hi  = (one <<< (cb - 1)) - one;
    lo  = -hi - one;
    if (v > hi) begin
      r = hi;
    end else if (v < lo) begin
      r = lo;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/vsc_if.sv
// Valid/ready channel interfaces for command items and result items.
`timescale 1ns / 1ps
`default_nettype none

interface vsc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [15:0] px;
  logic signed [15:0] py;
  logic [14:0]        rect_w;
  logic [14:0]        rect_h;

  modport source (output valid, kind, px, py, rect_w, rect_h, input ready);
  modport sink (input valid, kind, px, py, rect_w, rect_h, output ready);
endinterface

interface vsc_out_if #(
  parameter int COORD_BITS = vsc_pkg::COORD_BITS_DEF
);
  logic                    valid;
  logic                    ready;
  logic signed [COORD_BITS-1:0] origin_x;
  logic signed [COORD_BITS-1:0] origin_y;
  logic signed [COORD_BITS:0]   draw_y;

  modport source (output valid, origin_x, origin_y, draw_y, input ready);
  modport sink (input valid, origin_x, origin_y, draw_y, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/vsc_front.sv
// Front end: accepts command items and turns them into origin operations.
`timescale 1ns / 1ps
`default_nettype none

module vsc_front #(
  parameter int COORD_BITS = vsc_pkg::COORD_BITS_DEF,
  parameter int PW = (COORD_BITS > 16) ? COORD_BITS : 16
) (
  input  vsc_pkg::cfg_t          cfg_i,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic [1:0]             kind_i,
  input  logic signed [15:0]     px_i,
  input  logic signed [15:0]     py_i,
  input  logic [14:0]            rect_w_i,
  input  logic [14:0]            rect_h_i,
  output logic                   push_valid_o,
  input  logic                   push_ready_i,
  output vsc_pkg::op_e           op_o,
  output logic signed [PW-1:0]   tx_o,
  output logic signed [PW-1:0]   ty_o
);
  import vsc_pkg::*;

  localparam int FW = PW + 2;

  logic signed [FW-1:0] px_w, py_w;
  logic signed [FW-1:0] midx_w, midy_w;
  logic signed [FW-1:0] cx_w, cy_w;
  logic signed [FW-1:0] offx_w, offy_w;
  logic                 margin_en;

  assign margin_en    = cfg_i.mode[MODE_MARGIN_BIT];
  assign push_valid_o = valid_i;
  assign ready_o      = push_ready_i;

  always_comb begin
    px_w   = FW'(px_i);
    py_w   = FW'(py_i);
    midx_w = px_w + signed'(FW'(rect_w_i >> 1));
    midy_w = py_w + signed'(FW'(rect_h_i >> 1));
    // Rectangle middle saturates before it is used as a point.
    if (kind_e'(kind_i) == KIND_RECT) begin
      cx_w = FW'(COORD_BITS'(sat_coord(SAT_W'(midx_w), COORD_BITS)));
      cy_w = FW'(COORD_BITS'(sat_coord(SAT_W'(midy_w), COORD_BITS)));
    end else begin
      cx_w = px_w;
      cy_w = py_w;
    end
    offx_w = cx_w - signed'(FW'(cfg_i.view_w >> 1));
    offy_w = cy_w - signed'(FW'(cfg_i.view_h >> 1));

    case (kind_e'(kind_i))
      KIND_GOTO: begin
        op_o = OP_ABS;
        tx_o = PW'(px_i);
        ty_o = PW'(py_i);
      end
      KIND_MOVE: begin
        op_o = OP_REL;
        tx_o = PW'(px_i);
        ty_o = PW'(py_i);
      end
      KIND_CENTER, KIND_RECT: begin
        if (margin_en) begin
          op_o = OP_MARGIN;
          tx_o = PW'(cx_w);
          ty_o = PW'(cy_w);
        end else begin
          op_o = OP_ABS;
          tx_o = PW'(COORD_BITS'(sat_coord(SAT_W'(offx_w), COORD_BITS)));
          ty_o = PW'(COORD_BITS'(sat_coord(SAT_W'(offy_w), COORD_BITS)));
        end
      end
      default: begin
        op_o = OP_ABS;
        tx_o = PW'(px_i);
        ty_o = PW'(py_i);
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/vsc_queue.sv
// Short FIFO that decouples the front end from the back end.
`timescale 1ns / 1ps
`default_nettype none

module vsc_queue #(
  parameter int DW = 34
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  logic [DW-1:0] push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output logic [DW-1:0] pop_data_o
);
  import vsc_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [DW-1:0]    mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(QUEUE_DEPTH))
    else $error("queue fill count above depth");

  a_cnt_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue fill count missed a push");

endmodule

`default_nettype wire

FILE: hw/rtl/vsc_back.sv
// Back end: holds the view origin, applies dead zone and limits, drives results.
`timescale 1ns / 1ps
`default_nettype none

module vsc_back #(
  parameter int COORD_BITS = vsc_pkg::COORD_BITS_DEF,
  parameter int PW = (COORD_BITS > 16) ? COORD_BITS : 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  vsc_pkg::cfg_t                cfg_i,
  input  logic                         q_valid_i,
  output logic                         q_ready_o,
  input  vsc_pkg::op_e                 op_i,
  input  logic signed [PW-1:0]         tx_i,
  input  logic signed [PW-1:0]         ty_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [COORD_BITS-1:0] origin_x_o,
  output logic signed [COORD_BITS-1:0] origin_y_o,
  output logic signed [COORD_BITS:0]   draw_y_o
);
  import vsc_pkg::*;

  localparam int BW = ((COORD_BITS > 18) ? COORD_BITS : 18) + 3;

  logic signed [COORD_BITS-1:0] org_x_q, org_y_q, nxt_x, nxt_y;
  logic signed [COORD_BITS:0]   draw_y_q, draw_y_d;
  logic                         out_valid_q;
  logic                         pop, hold;

  logic signed [BW-1:0] ox, oy, txe, tye, rx, ry, dx, dy;
  logic signed [BW-1:0] pre_x, pre_y, p_x, p_y, fin_x, fin_y, dyw;

  function automatic logic signed [BW-1:0] sat_b(input logic signed [BW-1:0] v);
    return BW'(sat_coord(SAT_W'(v), COORD_BITS));
  endfunction

  // Distance of v outside [lo, lo + len]; edges count as inside.
  function automatic logic signed [BW-1:0] outside_f(input logic signed [BW-1:0] v,
                                                     input logic signed [BW-1:0] lo,
                                                     input logic signed [BW-1:0] len);
    logic signed [BW-1:0] hi;
    logic signed [BW-1:0] r;
    hi = lo + len;
    if (v < lo) begin
      r = v - lo;
    end else if (v > hi) begin
      r = v - hi;
    end else begin
      r = '0;
    end
    return r;
  endfunction

  function automatic logic signed [BW-1:0] clamp_f(input logic signed [BW-1:0] view,
                                                   input logic signed [BW-1:0] lo,
                                                   input logic signed [BW-1:0] len,
                                                   input logic signed [BW-1:0] pos);
    logic signed [BW-1:0] d;
    logic signed [BW-1:0] r;
    d = len - view;
    if (view <= len) begin
      if (pos < lo) begin
        r = lo;
      end else if (pos + view > lo + len) begin
        r = lo + d;
      end else begin
        r = pos;
      end
    end else begin
      // d is negative here: round the half toward zero.
      r = lo + ((d + BW'(signed'(1))) >>> 1);
    end
    return r;
  endfunction

  assign q_ready_o   = !out_valid_q || out_ready_i;
  assign pop         = q_valid_i && q_ready_o;
  assign out_valid_o = out_valid_q;
  assign origin_x_o  = org_x_q;
  assign origin_y_o  = org_y_q;
  assign draw_y_o    = draw_y_q;

  always_comb begin
    ox  = BW'(org_x_q);
    oy  = BW'(org_y_q);
    txe = BW'(tx_i);
    tye = BW'(ty_i);
    rx  = sat_b(txe - ox);
    ry  = sat_b(tye - oy);
    dx  = outside_f(rx, BW'(signed'(cfg_i.margin_origin[15:0])),
                    signed'(BW'(cfg_i.margin_size[15:0])));
    dy  = outside_f(ry, BW'(signed'(cfg_i.margin_origin[31:16])),
                    signed'(BW'(cfg_i.margin_size[31:16])));

    case (op_i)
      OP_ABS: begin
        pre_x = txe;
        pre_y = tye;
      end
      OP_REL: begin
        pre_x = ox + txe;
        pre_y = oy + tye;
      end
      OP_MARGIN: begin
        pre_x = ox + dx;
        pre_y = oy + dy;
      end
      default: begin
        pre_x = txe;
        pre_y = tye;
      end
    endcase

    // Point inside the dead zone: leave the origin alone, skip the clamp.
    hold = (op_i == OP_MARGIN) && (dx == '0) && (dy == '0);

    p_x = sat_b(pre_x);
    p_y = sat_b(pre_y);
    if (cfg_i.mode[MODE_LIMIT_BIT]) begin
      fin_x = sat_b(clamp_f(signed'(BW'(cfg_i.view_w)),
                            BW'(signed'(cfg_i.lim_base[15:0])),
                            signed'(BW'(cfg_i.limit_size[15:0])), p_x));
      fin_y = sat_b(clamp_f(signed'(BW'(cfg_i.view_h)),
                            BW'(signed'(cfg_i.lim_base[31:16])),
                            signed'(BW'(cfg_i.limit_size[31:16])), p_y));
    end else begin
      fin_x = p_x;
      fin_y = p_y;
    end

    nxt_x = hold ? org_x_q : COORD_BITS'(fin_x);
    nxt_y = hold ? org_y_q : COORD_BITS'(fin_y);

    if (cfg_i.mode[MODE_CART_BIT]) begin
      dyw = -BW'(nxt_y) - signed'(BW'(cfg_i.view_h));
    end else begin
      dyw = BW'(nxt_y);
    end
    draw_y_d = (COORD_BITS + 1)'(dyw);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      org_x_q     <= '0;
      org_y_q     <= '0;
    end else begin
      if (q_ready_o) begin
        out_valid_q <= q_valid_i;
      end
      if (pop) begin
        org_x_q <= nxt_x;
        org_y_q <= nxt_y;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      draw_y_q <= draw_y_d;
    end
  end

  a_hold_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && hold) |=> ($stable(org_x_q) && $stable(org_y_q)))
    else $error("origin moved for a point inside the dead zone");

  a_stall_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=>
      (out_valid_q && $stable(org_x_q) && $stable(org_y_q) && $stable(draw_y_q)))
    else $error("result or origin changed while the receiver stalled");

endmodule

`default_nettype wire

FILE: hw/rtl/viewport_scroll_clamp.sv
// Top level of the viewport scroll clamp: config registers, front, queue, back.
//
// Usage: commands arrive as items on in_i (go to, move by, center on a point,
// center on a rectangle). Each command yields exactly one result item on out_o
// carrying the new view origin and the draw offset y.
// Configuration registers are written through cfg_we_i / cfg_idx_i / cfg_data_i;
// the user must do so only while no command is in flight, as the block does not
// enforce it. Indexes past the last register are ignored. With the queue empty,
// a command passes the queue entry and then the result register before its
// result can be taken.
// Throughput: one command per cycle while out_o.ready is high, set by the origin
// update in the back end, which feeds the origin register back into the next command.
// Stalls: the result register holds while out_o.ready is low; the two-entry
// queue keeps taking commands until it fills, then in_i.ready drops.
// Reset: origin goes to (0, 0), mode to 0, view to 320x240, all rectangles to 0;
// the queue and result register are emptied.
`timescale 1ns / 1ps
`default_nettype none

module viewport_scroll_clamp #(
  parameter int COORD_BITS = vsc_pkg::COORD_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  vsc_in_if.sink      in_i,
  vsc_out_if.source   out_o
);
  import vsc_pkg::*;

  localparam int PW = (COORD_BITS > 16) ? COORD_BITS : 16;
  localparam int DW = 2 + 2 * PW;

  cfg_t cfg_q, cfg_d;

  logic                 f_valid, f_ready;
  op_e                  f_op;
  logic signed [PW-1:0] f_tx, f_ty;
  logic [DW-1:0]        push_data, pop_data;
  logic                 q_valid, q_ready;
  logic signed [COORD_BITS-1:0] res_x, res_y;
  logic signed [COORD_BITS:0]   res_dy;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MODE:          cfg_d.mode          = cfg_data_i[2:0];
        CFG_VIEW_W:        cfg_d.view_w        = cfg_data_i[14:0];
        CFG_VIEW_H:        cfg_d.view_h        = cfg_data_i[14:0];
        CFG_LIM_BASE:      cfg_d.lim_base      = cfg_data_i;
        CFG_LIMIT_SIZE:    cfg_d.limit_size    = cfg_data_i;
        CFG_MARGIN_ORIGIN: cfg_d.margin_origin = cfg_data_i;
        CFG_MARGIN_SIZE:   cfg_d.margin_size   = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode          <= '0;
      cfg_q.view_w        <= 15'(VIEW_W_RST);
      cfg_q.view_h        <= 15'(VIEW_H_RST);
      cfg_q.lim_base      <= '0;
      cfg_q.limit_size    <= '0;
      cfg_q.margin_origin <= '0;
      cfg_q.margin_size   <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  vsc_front #(
    .COORD_BITS (COORD_BITS),
    .PW         (PW)
  ) u_front (
    .cfg_i        (cfg_q),
    .valid_i      (in_i.valid),
    .ready_o      (in_i.ready),
    .kind_i       (in_i.kind),
    .px_i         (in_i.px),
    .py_i         (in_i.py),
    .rect_w_i     (in_i.rect_w),
    .rect_h_i     (in_i.rect_h),
    .push_valid_o (f_valid),
    .push_ready_i (f_ready),
    .op_o         (f_op),
    .tx_o         (f_tx),
    .ty_o         (f_ty)
  );

  assign push_data = {f_op, f_tx, f_ty};

  vsc_queue #(
    .DW (DW)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (pop_data)
  );

  vsc_back #(
    .COORD_BITS (COORD_BITS),
    .PW         (PW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .op_i        (op_e'(pop_data[DW-1 -: 2])),
    .tx_i        (signed'(pop_data[2*PW-1 -: PW])),
    .ty_i        (signed'(pop_data[PW-1:0])),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .origin_x_o  (res_x),
    .origin_y_o  (res_y),
    .draw_y_o    (res_dy)
  );

  assign out_o.origin_x = res_x;
  assign out_o.origin_y = res_y;
  assign out_o.draw_y   = res_dy;

endmodule

`default_nettype wire
